>>> sv/febps_pkg.sv
// Shared types and constants of the erase-before-program sequencer.
`timescale 1ns / 1ps
package febps_pkg;

    localparam int unsigned MAX_SECTORS = 12;
    localparam int unsigned OFF_W = 21;    // offsets within the 1 MB map
    localparam int unsigned SEC_IDX_W = 4;

    // End offset of each sector, in bytes above the base.
    localparam logic [OFF_W-1:0] SECTOR_END [MAX_SECTORS] = '{
        21'h004000, 21'h008000, 21'h00C000, 21'h010000,
        21'h020000, 21'h040000, 21'h060000, 21'h080000,
        21'h0A0000, 21'h0C0000, 21'h0E0000, 21'h100000
    };

    localparam logic [31:0] FLASH_BASE_RST = 32'h0800_0000;

    typedef enum logic [1:0] {
        KIND_ERASE   = 2'd0,
        KIND_PROGRAM = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic                 hit;      // address lies inside the map
        logic [SEC_IDX_W-1:0] sector;
    } t_loc;

    typedef struct packed {
        t_kind                kind;
        logic [SEC_IDX_W-1:0] sector_index;
        logic [31:0]          prog_address;
        logic [31:0]          prog_data;
        logic                 run_last;
    } t_result;

endpackage

>>> sv/febps_word_if.sv
// Input word channel: address, data and block-end mark.
`timescale 1ns / 1ps
interface febps_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_address;
    logic [31:0] word_data;
    logic        block_last;

    modport source (output valid, word_address, word_data, block_last, input ready);
    modport sink   (input valid, word_address, word_data, block_last, output ready);
endinterface

>>> sv/febps_cmd_if.sv
// Result channel: erase, program and error commands.
`timescale 1ns / 1ps
interface febps_cmd_if;
    logic                               valid;
    logic                               ready;
    febps_pkg::t_kind                   kind;
    logic [febps_pkg::SEC_IDX_W-1:0]    sector_index;
    logic [31:0]                        prog_address;
    logic [31:0]                        prog_data;
    logic                               run_last;

    modport source (output valid, kind, sector_index, prog_address, prog_data, run_last,
                    input ready);
    modport sink   (input valid, kind, sector_index, prog_address, prog_data, run_last,
                    output ready);
endinterface

>>> sv/febps_cfg_if.sv
// Configuration write channel carrying the flash base address.
`timescale 1ns / 1ps
interface febps_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/flash_erase_before_program_sequencer_top.sv
// Top level of the erase-before-program flash sequencer.
//
//  channel  | dir | payload                                              | accepted when
//  ---------+-----+------------------------------------------------------+---------------
//  i_word   | in  | word_address, word_data, block_last                  | valid & ready
//  o_cmd    | out | kind, sector_index, prog_address, prog_data, run_last| valid & ready
//  i_cfg    | in  | data (flash base address)                            | valid & ready
//
// An accepted word lands in an input register, where it is decoded and its
// zero, one or two commands go into a two-slot output buffer. One word per
// cycle is sustained while each word yields at most one command and o_cmd
// does not stall; a word needing an erase first sends two commands through one port.
// Synchronous active-low reset clears the erased marks, the skip flag and all
// valid flags, and reloads the base to 0x0800_0000. A stall on o_cmd backs up
// into the input register and then drops i_word.ready.
`timescale 1ns / 1ps
module flash_erase_before_program_sequencer_top #(
    parameter int SECTOR_COUNT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    febps_word_if.sink  i_word,
    febps_cmd_if.source o_cmd,
    febps_cfg_if.sink   i_cfg
);
    localparam int SEC_W = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;

    // base register
    logic [31:0] r_base;

    // input register
    logic        r_in_vld;
    logic [31:0] r_in_addr;
    logic [31:0] r_in_data;
    logic        r_in_last;

    // sequencer state
    logic [SECTOR_COUNT-1:0] r_erased, n_erased;
    logic                    r_skip, n_skip;

    // output buffer: slot 0 is shown on the port
    logic [1:0]         r_cnt, n_cnt;
    febps_pkg::t_result r_slot0, r_slot1, n_slot0, n_slot1;

    febps_pkg::t_loc    loc;
    febps_pkg::t_result res0, res1;
    logic [1:0]         nres, free, rem_cnt, push;
    logic               pop, adv, is_err, need_erase;
    logic [SEC_W-1:0]   sec_idx;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= febps_pkg::FLASH_BASE_RST;
        end else if (i_cfg.valid) begin
            r_base <= i_cfg.data;
        end
    end

    febps_locate #(.SECTOR_COUNT(SECTOR_COUNT)) u_locate (
        .i_addr (r_in_addr),
        .i_base (r_base),
        .o_loc  (loc)
    );

    assign sec_idx    = loc.sector[SEC_W-1:0];
    assign is_err     = !loc.hit || (loc.sector == '0);
    assign need_erase = !r_erased[sec_idx];

    // build this word's commands
    always_comb begin
        res0 = '0;
        res1 = '0;
        nres = 2'd0;
        if (!r_skip) begin
            if (is_err) begin
                res0.kind     = febps_pkg::KIND_ERROR;
                res0.run_last = 1'b1;
                nres          = 2'd1;
            end else begin
                res1.kind         = febps_pkg::KIND_PROGRAM;
                res1.sector_index = loc.sector;
                res1.prog_address = r_in_addr;
                res1.prog_data    = {r_in_data[7:0], r_in_data[15:8],
                                     r_in_data[23:16], r_in_data[31:24]};
                res1.run_last     = 1'b1;
                if (need_erase) begin
                    res0.kind         = febps_pkg::KIND_ERASE;
                    res0.sector_index = loc.sector;
                    nres              = 2'd2;
                end else begin
                    res0 = res1;
                    nres = 2'd1;
                end
            end
        end
    end

    assign pop     = o_cmd.valid && o_cmd.ready;
    assign rem_cnt = r_cnt - {1'b0, pop};
    assign free    = 2'd2 - rem_cnt;
    assign adv     = r_in_vld && (nres <= free);
    assign push    = adv ? nres : 2'd0;
    assign i_word.ready = !r_in_vld || adv;

    // state updates for the word being decoded
    always_comb begin
        n_erased = r_erased;
        n_skip   = r_skip;
        if (adv) begin
            if (r_skip) begin
                n_skip = !r_in_last;
            end else if (is_err) begin
                n_skip = !r_in_last;
            end else begin
                n_erased[sec_idx] = 1'b1;
            end
        end
    end

    // output buffer: drop the popped command, append new ones
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (pop) begin
            n_slot0 = r_slot1;
        end
        if (rem_cnt == 2'd0) begin
            n_slot0 = res0;
            n_slot1 = res1;
        end else if (rem_cnt == 2'd1) begin
            n_slot1 = res0;
        end
        n_cnt = rem_cnt + push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_erased <= '0;
            r_skip   <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_word.ready) begin
                r_in_vld <= i_word.valid;
            end
            r_erased <= n_erased;
            r_skip   <= n_skip;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.ready && i_word.valid) begin
            r_in_addr <= i_word.word_address;
            r_in_data <= i_word.word_data;
            r_in_last <= i_word.block_last;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_cmd.valid        = (r_cnt != 2'd0);
    assign o_cmd.kind         = r_slot0.kind;
    assign o_cmd.sector_index = r_slot0.sector_index;
    assign o_cmd.prog_address = r_slot0.prog_address;
    assign o_cmd.prog_data    = r_slot0.prog_data;
    assign o_cmd.run_last     = r_slot0.run_last;
endmodule

>>> sv/febps_locate.sv
// Sector lookup: parallel compares of the base offset against fixed sector ends.
`timescale 1ns / 1ps
module febps_locate #(
    parameter int SECTOR_COUNT = 12
) (
    input  logic [31:0]     i_addr,
    input  logic [31:0]     i_base,
    output febps_pkg::t_loc o_loc
);
    logic [32:0] diff;
    logic [31:0] off;
    logic        in_map;

    assign diff = {1'b0, i_addr} - {1'b0, i_base};
    assign off  = diff[31:0];
    // borrow means below base; the map end never wraps past 2^32
    assign in_map = !diff[32]
                 && (off < {11'd0, febps_pkg::SECTOR_END[SECTOR_COUNT-1]});

    always_comb begin
        o_loc.hit    = in_map;
        o_loc.sector = '0;
        for (int i = 1; i < SECTOR_COUNT; i++) begin
            if (off >= {11'd0, febps_pkg::SECTOR_END[i-1]}) begin
                o_loc.sector = febps_pkg::SEC_IDX_W'(i);
            end
        end
    end
endmodule

>>> tb/febps_cmd_checker.sv
// Watches the word, command and base channels, decodes each word and checks every command.
`timescale 1ns / 1ps
module febps_cmd_checker #(
    parameter int SECTOR_COUNT = 12
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    febps_word_if i_word,
    febps_cmd_if  i_cmd,
    febps_cfg_if  i_cfg,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_words_seen,
    output int    o_words_decoded,
    output int    o_cmds_seen,
    output int    o_erases_seen
);
    import febps_pkg::*;

    localparam int unsigned KB = 1024;

    logic [31:0]            base_addr;
    logic [MAX_SECTORS-1:0] sector_erased;
    logic                   skip_block;
    t_result                due_cmds[$];
    int                     fails = 0;
    int                     words_seen = 0;
    int                     words_decoded = 0;
    int                     cmds_seen = 0;
    int                     erases_seen = 0;

    function automatic logic [32:0] sector_bytes(int s);
        if (s < 4) return 33'(16 * KB);
        if (s == 4) return 33'(64 * KB);
        return 33'(128 * KB);
    endfunction

    // 33-bit bounds: a map running past the top of the address space just ends there.
    function automatic int find_sector(logic [31:0] addr, logic [31:0] base);
        logic [32:0] lo;
        logic [32:0] hi;
        lo = {1'b0, base};
        for (int s = 0; s < SECTOR_COUNT && s < MAX_SECTORS; s++) begin
            hi = lo + sector_bytes(s);
            if ({1'b0, addr} >= lo && {1'b0, addr} < hi) return s;
            lo = hi;
        end
        return -1;
    endfunction

    function automatic t_result make_cmd(t_kind k, int sec, logic [31:0] addr,
                                         logic [31:0] data, logic last);
        t_result r;
        r.kind         = k;
        r.sector_index = SEC_IDX_W'(sec);
        r.prog_address = addr;
        r.prog_data    = data;
        r.run_last     = last;
        return r;
    endfunction

    task automatic decode_word(logic [31:0] addr, logic [31:0] data, logic last);
        int sec;
        if (skip_block) begin
            if (last) skip_block = 1'b0;
        end else begin
            words_decoded++;
            sec = find_sector(addr, base_addr);
            if (sec <= 0) begin
                // outside flash or protected sector 0
                due_cmds.push_back(make_cmd(KIND_ERROR, 0, '0, '0, 1'b1));
                if (!last) skip_block = 1'b1;
            end else begin
                if (!sector_erased[sec]) begin
                    due_cmds.push_back(make_cmd(KIND_ERASE, sec, '0, '0, 1'b0));
                    sector_erased[sec] = 1'b1;
                end
                due_cmds.push_back(make_cmd(KIND_PROGRAM, sec, addr,
                    {data[7:0], data[15:8], data[23:16], data[31:24]}, 1'b1));
            end
        end
    endtask

    task automatic compare_cmd();
        t_result want;
        cmds_seen++;
        if (i_cmd.kind == KIND_ERASE) erases_seen++;
        if (due_cmds.size() == 0) begin
            $error({"unexpected command: kind %0d sector_index %0d prog_address %h",
                    " prog_data %h run_last %b"},
                   i_cmd.kind, i_cmd.sector_index, i_cmd.prog_address, i_cmd.prog_data,
                   i_cmd.run_last);
            fails++;
        end else begin
            want = due_cmds.pop_front();
            if (i_cmd.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, i_cmd.kind);
                fails++;
            end
            if (i_cmd.sector_index !== want.sector_index) begin
                $error("sector_index: expected %0d, got %0d", want.sector_index,
                       i_cmd.sector_index);
                fails++;
            end
            if (i_cmd.prog_address !== want.prog_address) begin
                $error("prog_address: expected %h, got %h", want.prog_address,
                       i_cmd.prog_address);
                fails++;
            end
            if (i_cmd.prog_data !== want.prog_data) begin
                $error("prog_data: expected %h, got %h", want.prog_data, i_cmd.prog_data);
                fails++;
            end
            if (i_cmd.run_last !== want.run_last) begin
                $error("run_last: expected %b, got %b", want.run_last, i_cmd.run_last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_addr     = FLASH_BASE_RST;
            sector_erased = '0;
            skip_block    = 1'b0;
            due_cmds.delete();
        end else begin
            // a word accepted now cannot have its command out at the same edge
            if (i_cmd.valid && i_cmd.ready) compare_cmd();
            if (i_cfg.valid && i_cfg.ready) base_addr = i_cfg.data;
            if (i_word.valid && i_word.ready) begin
                words_seen++;
                decode_word(i_word.word_address, i_word.word_data, i_word.block_last);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= due_cmds.size();
        o_words_seen    <= words_seen;
        o_words_decoded <= words_decoded;
        o_cmds_seen     <= cmds_seen;
        o_erases_seen   <= erases_seen;
    end

endmodule

>>> tb/tb_flash_erase_before_program_sequencer_top.sv
// Top of the sequencer testbench: clock, reset, word and base stimulus, sink and verdict.
`timescale 1ns / 1ps
module tb_flash_erase_before_program_sequencer_top;
    import febps_pkg::*;

    localparam int          SECTOR_COUNT = 12;
    localparam int          CLK_PERIOD   = 10;
    localparam int unsigned KB           = 1024;
    localparam logic [31:0] MAP_BYTES    = 32'h0010_0000;  // 16*4 + 64 + 128*7 kB
    localparam int          SEGMENTS     = 8;
    localparam int          SEG_WORDS    = 80;   // accepted words per random segment
    localparam int          HOLD_CYCLES  = 200;  // long sink hold-off, fills the block
    localparam int          IDLE_PAD     = 8;    // covers words that make no command
    localparam int          END_WAIT     = 5000;

    // Per-phase idle percentages: none, sender only, sink only, both.
    localparam int SEND_IDLE[4]  = '{0, 50, 0, 23};
    localparam int RECV_STALL[4] = '{0, 0, 50, 23};

    logic clk = 1'b0;
    logic rst_n;

    febps_word_if word_ch ();
    febps_cmd_if  cmd_ch ();
    febps_cfg_if  cfg_ch ();

    int fail_count;
    int pending;
    int words_seen;
    int words_decoded;
    int cmds_seen;
    int erases_seen;

    // Stimulus settings; the stall percentage and hold requests are shared with the sink process.
    logic [31:0] cur_base       = FLASH_BASE_RST;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    flash_erase_before_program_sequencer_top #(
        .SECTOR_COUNT(SECTOR_COUNT)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_word  (word_ch),
        .o_cmd   (cmd_ch),
        .i_cfg   (cfg_ch)
    );

    // Prediction and comparison live here; the top only stimulates and judges.
    febps_cmd_checker #(
        .SECTOR_COUNT(SECTOR_COUNT)
    ) u_cmd_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_word          (word_ch),
        .i_cmd           (cmd_ch),
        .i_cfg           (cfg_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_seen    (words_seen),
        .o_words_decoded (words_decoded),
        .o_cmds_seen     (cmds_seen),
        .o_erases_seen   (erases_seen)
    );

    // Sector sizes of the fixed map, used to aim addresses at sectors and their edges.
    function automatic logic [31:0] sector_span(int s);
        if (s < 4) return 16 * KB;
        if (s == 4) return 64 * KB;
        return 128 * KB;
    endfunction

    function automatic logic [31:0] sector_offset(int s);
        logic [31:0] off;
        off = '0;
        for (int i = 0; i < s; i++) off += sector_span(i);
        return off;
    endfunction

    // Mostly addresses inside writable sectors (first byte, last byte or anywhere),
    // the rest split over sector 0, below the base, past the map and fully random.
    function automatic logic [31:0] pick_address(logic [31:0] base);
        int unsigned roll;
        int          s;
        logic [31:0] span;
        roll = $urandom_range(99);
        if (roll < 80) begin
            s    = $urandom_range(SECTOR_COUNT - 1, 1);
            span = sector_span(s);
            case ($urandom_range(3))
                0: return base + sector_offset(s);
                1: return base + sector_offset(s) + span - 1;
                default: return base + sector_offset(s) + $urandom_range(span - 1);
            endcase
        end
        if (roll < 85) return base + $urandom_range(16 * KB - 1);
        if (roll < 90) return base - 32'd1 - $urandom_range(4095);
        if (roll < 95) return base + MAP_BYTES + $urandom_range(4095);
        return $urandom;
    endfunction

    // Offer one word, with random idle cycles ahead of it; returns at the accepting edge.
    // valid stays high on return so back-to-back words need no second assignment.
    task automatic send_word(logic [31:0] addr, logic [31:0] data, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            word_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_ch.valid        <= 1'b1;
        word_ch.word_address <= addr;
        word_ch.word_data    <= data;
        word_ch.block_last   <= last;
        @(posedge clk);
        while (!word_ch.ready) @(posedge clk);
    endtask

    // Stop offering words and wait until every expected command is out.
    // The first wait lets the checker's count include the word accepted last.
    task automatic wait_idle();
        word_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_base(logic [31:0] base);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= base;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_base = base;
    endtask

    // A write block of 1..6 words. Most are well formed and end with block_last;
    // the rest is noise with random addresses and random block ends.
    task automatic send_block();
        int len;
        len = $urandom_range(6, 1);
        if ($urandom_range(99) < 85) begin
            for (int i = 0; i < len; i++)
                send_word(pick_address(cur_base), $urandom, i == len - 1);
        end else begin
            for (int i = 0; i < len; i++)
                send_word($urandom, $urandom, 1'($urandom_range(1)));
        end
    endtask

    // Command sink: random stalls per phase, plus a long hold-off on request.
    initial begin : cmd_sink
        int hold_left;
        int holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        cmd_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_taken) begin
                holds_taken = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                cmd_ch.ready <= 1'b0;
            end else begin
                cmd_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Main stimulus.
    initial begin : stimulus
        logic [31:0] seg_base[SEGMENTS];
        logic [31:0] b;
        int          goal;
        int          waited;
        bit          paused;

        rst_n                <= 1'b0;
        word_ch.valid        <= 1'b0;
        word_ch.word_address <= '0;
        word_ch.word_data    <= '0;
        word_ch.block_last   <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.data          <= '0;

        // Base per segment: reset value, both extremes, a map ending exactly at the top
        // of the address space, one cut short by it, random ones, and back to reset.
        seg_base[0] = FLASH_BASE_RST;
        seg_base[1] = 32'h0000_0000;
        seg_base[2] = 32'hFFF0_0000;
        seg_base[3] = 32'hFFFF_FFFF;
        seg_base[4] = 32'hFFF8_0000;
        seg_base[5] = $urandom & 32'hFFFF_C000;
        seg_base[6] = $urandom;
        seg_base[7] = FLASH_BASE_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words against the reset base, no idling on either side.
        b = cur_base;
        send_word(b - 32'd1, 32'hA5A5_5A5A, 1'b1);          // just below the base
        send_word(32'h0000_0000, 32'h0000_0000, 1'b1);      // lowest address
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);      // highest address
        send_word(b + MAP_BYTES, 32'h1234_5678, 1'b1);      // first byte past the map
        send_word(b, 32'h0102_0304, 1'b1);                  // protected sector, first byte
        send_word(b + 32'h3FFF, 32'h8000_0001, 1'b1);       // protected sector, last byte
        send_word(b + 32'h4000, 32'h1122_3344, 1'b0);       // sector 1: erase then program
        send_word(b + 32'h7FFF, 32'hDEAD_BEEF, 1'b1);       // sector 1 again: program only
        send_word(b + MAP_BYTES - 1, 32'hFFFF_FFFF, 1'b1);  // last byte of the last sector
        // error before the block's last word: the rest of the block is dropped
        send_word(b + 32'h0100, 32'h0000_0000, 1'b0);
        send_word(b + 32'h8000, 32'h5555_AAAA, 1'b0);
        send_word(b + 32'h2_0000, 32'hAAAA_5555, 1'b1);
        send_word(b + 32'h8000, 32'h0000_0000, 1'b1);       // decoded again after block end
        // error on the last word: nothing skipped afterwards
        send_word(b - 32'h4, 32'h0F0F_0F0F, 1'b1);
        send_word(b + 32'h1_0000, 32'hF0F0_F0F0, 1'b1);
        send_word(b + 32'h2_0000, 32'h7F00_00FE, 1'b0);
        send_word(b + 32'h4_0000, 32'h0123_4567, 1'b0);
        send_word(b + MAP_BYTES + 32'h10, 32'h89AB_CDEF, 1'b0);  // past map mid-block
        send_word(b + 32'h4_0000, 32'hFEDC_BA98, 1'b1);          // dropped
        wait_idle();

        // Random segments, each with its own base and handshake mix.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg > 0) write_base(seg_base[seg]);
            send_idle_pct  = SEND_IDLE[seg % 4];
            recv_stall_pct = RECV_STALL[seg % 4];
            // long sink hold-off while words keep coming, backs up into the input
            if (seg == 2) hold_requests++;
            goal   = words_seen + SEG_WORDS;
            paused = 1'b0;
            while (words_seen < goal) begin
                // one pause per segment until the output has drained
                if (!paused && words_seen >= goal - SEG_WORDS / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
                send_block();
            end
        end

        // Drain: wait for the last commands, bounded, then the idle pad.
        word_ch.valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < END_WAIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (IDLE_PAD) @(posedge clk);

        $display("Ran %0d words (%0d decoded, rest dropped in failed blocks),",
                 words_seen, words_decoded);
        $display("%0d commands, %0d erases.", cmds_seen, erases_seen);
        $display("Bases: reset, zero, all ones, top-aligned, clipped, random; four handshake mixes.");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            if (pending != 0) $error("%0d expected commands never came out", pending);
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : run_limit
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/febps_pkg.sv
sv/febps_word_if.sv
sv/febps_cmd_if.sv
sv/febps_cfg_if.sv
sv/febps_locate.sv
sv/flash_erase_before_program_sequencer_top.sv
tb/febps_cmd_checker.sv
tb/tb_flash_erase_before_program_sequencer_top.sv
